FILE: src/tdpt_pkg.sv
// tdpt_pkg: shared constants and types of the trial division prime test unit
// no dependencies; imported by the interfaces, the divider and the top level

package tdpt_pkg;

   // width of the candidate number
   localparam int NUMBER_BITS = 31;

   // width of the divider step counter, indexes steps 0 .. NUMBER_BITS-1
   localparam int CNT_W = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

   // first trial divisor
   localparam logic [NUMBER_BITS-1:0] TRIAL_FIRST = NUMBER_BITS'(2);

   // largest candidate that is never prime
   localparam logic [NUMBER_BITS-1:0] NOT_PRIME_MAX = NUMBER_BITS'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                   start;
      logic [NUMBER_BITS-1:0] dividend;
      logic [NUMBER_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [NUMBER_BITS-1:0] quotient;
      logic [NUMBER_BITS-1:0] remainder;
   } div_status_type;

endpackage

FILE: src/tdpt_if.sv
// tdpt_if: valid/ready channel interfaces for candidates and results
// depends on tdpt_pkg for the candidate width

interface tdpt_req_if
   import tdpt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if
   import tdpt_pkg::*;
();
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink   (input valid, input is_prime, output ready);
endinterface

FILE: src/tdpt_divider.sv
// tdpt_divider: restoring divider, one quotient bit per cycle
// depends on tdpt_pkg; gives quotient and remainder once its last step is done, flagged by done

module tdpt_divider
   import tdpt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  div_cmd_type    cmd,
   output div_status_type status
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NUMBER_BITS-1:0] rem_ff, rem_in;
   logic [NUMBER_BITS-1:0] quo_ff, quo_in;
   logic [NUMBER_BITS-1:0] dsr_ff, dsr_in;

   logic [NUMBER_BITS:0]   shifted;
   logic [NUMBER_BITS:0]   diff;
   logic                   fits;
   logic                   last_step;

   // quo_ff holds the dividend bits still to come in its top and the quotient in its bottom
   assign shifted   = {rem_ff, quo_ff[NUMBER_BITS-1]};
   assign diff      = shifted - {1'b0, dsr_ff};
   assign fits      = (shifted >= {1'b0, dsr_ff});
   assign last_step = (cnt_ff == CNT_W'(NUMBER_BITS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[NUMBER_BITS-1:0] : shifted[NUMBER_BITS-1:0];
         quo_in = {quo_ff[NUMBER_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

endmodule

FILE: src/trial_division_prime_test_unit.sv
// Trial division prime test: one candidate in, one is_prime flag out.
// Candidates 0 and 1 are reported not prime without a division; otherwise the serial
// divider divides the candidate by each trial divisor in turn, from 2 up to the
// first factor or to floor(sqrt(candidate))+1, whichever comes first.
// Throughput: one candidate at a time; the next is taken once the result is registered.
// Reset: synchronous, active high, clears sequencer and output valid; no memories.

module trial_division_prime_test_unit
   import tdpt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   tdpt_req_if.sink   req,
   tdpt_rsp_if.source rsp
);

   seq_state_type          state_ff, state_in;
   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] d_ff, d_in;
   logic                   result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;

   div_cmd_type            div_cmd;
   div_status_type         div_status;

   logic                   req_xfer;
   logic                   small_cand;
   logic                   bound_passed;
   logic                   divides;
   logic                   out_load;

   tdpt_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_status)
   );

   assign req_xfer     = req.valid && req.ready;
   assign small_cand   = (req.candidate <= NOT_PRIME_MAX);
   // quotient below the divisor means every divisor up to the square root has been tried
   assign bound_passed = (div_status.quotient < d_ff);
   assign divides      = (div_status.remainder == '0);
   assign out_load     = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = small_cand ? S_FINISH : S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_status.done && (bound_passed || divides)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req.ready        = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = n_ff;
      div_cmd.divisor  = d_ff + 1'b1;
      n_in             = n_ff;
      d_in             = d_ff;
      result_in        = result_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      rsp_prime_in     = rsp_prime_ff;
      case (state_ff)
         S_IDLE: begin
            req.ready        = 1'b1;
            div_cmd.dividend = req.candidate;
            div_cmd.divisor  = TRIAL_FIRST;
            if (req_xfer) begin
               n_in      = req.candidate;
               d_in      = TRIAL_FIRST;
               result_in = 1'b0;
               div_cmd.start = !small_cand;
            end
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               if (bound_passed) begin
                  result_in = 1'b1;
               end else if (divides) begin
                  result_in = 1'b0;
               end else begin
                  d_in          = d_ff + 1'b1;
                  div_cmd.start = 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = result_ff;
            end
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      result_ff    <= result_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.is_prime = rsp_prime_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIVIDE))
      else $error("divider result outside divide state");

   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (d_ff >= TRIAL_FIRST))
      else $error("trial divisor below two");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && out_load |=> rsp_valid_ff && (rsp_prime_ff == $past(result_ff)))
      else $error("result not registered on finish");

endmodule
